FILE: design/tbeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbeq_pkg: shared types and constants for the three-band equalizer
// Fixed formats of the register file, the pole words and the shared
// multiplier operands.
// ---------------------------------------------------------------------------
package tbeq_pkg;

	localparam int REG_W      = 16;  // width of every configuration register
	localparam int PADDR_W    = 5;   // five registers at byte addresses 0..16
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = 3;

	localparam int COEFF_FRAC = 15;  // Q1.15 cutoff coefficients
	localparam int GAIN_FRAC  = 12;  // Q4.12 band gains
	localparam int POLE_W     = 32;  // signed pole word
	localparam int OPA_W      = 35;  // signal operand of the shared multiplier
	localparam int OPB_W      = 17;  // coefficient or gain, zero-extended
	localparam int PROD_W     = OPA_W + OPB_W;
	localparam int ACC_W      = 56;  // sum of three band products
	localparam int DELAY_DEPTH = 3;

	localparam logic [REG_IDX_W-1:0] REG_LOW_COEFF  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_COEFF = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOW_GAIN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MID_GAIN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_GAIN  = 3'd4;

	localparam logic [REG_W-1:0] GAIN_UNITY = 16'h1000;

	typedef struct packed {
		logic [REG_W-1:0] low_cutoff_coeff;
		logic [REG_W-1:0] high_cutoff_coeff;
		logic [REG_W-1:0] low_band_gain;
		logic [REG_W-1:0] mid_band_gain;
		logic [REG_W-1:0] high_band_gain;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [OPA_W-1:0]  a;   // two's complement
		logic [OPB_W-1:0]  b;   // two's complement
	} mul_req_t;

endpackage
`default_nettype wire

FILE: design/tbeq_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbeq_regs: configuration register file
// APB-style slave holding cutoff coefficients and band gains.
// ---------------------------------------------------------------------------
module tbeq_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tbeq_pkg::PADDR_W-1:0] paddr,
	input  wire logic [tbeq_pkg::PDATA_W-1:0] pwdata,
	output logic      [tbeq_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	output tbeq_pkg::cfg_t                    cfg
);
	import tbeq_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	logic [REG_W-1:0]     rd_val;

	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_cutoff_coeff  <= '0;
			cfg_q.high_cutoff_coeff <= '0;
			cfg_q.low_band_gain     <= GAIN_UNITY;
			cfg_q.mid_band_gain     <= GAIN_UNITY;
			cfg_q.high_band_gain    <= GAIN_UNITY;
		end else if (wr_en) begin
			unique case (idx)
				REG_LOW_COEFF:  cfg_q.low_cutoff_coeff  <= pwdata[REG_W-1:0];
				REG_HIGH_COEFF: cfg_q.high_cutoff_coeff <= pwdata[REG_W-1:0];
				REG_LOW_GAIN:   cfg_q.low_band_gain     <= pwdata[REG_W-1:0];
				REG_MID_GAIN:   cfg_q.mid_band_gain     <= pwdata[REG_W-1:0];
				REG_HIGH_GAIN:  cfg_q.high_band_gain    <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LOW_COEFF:  rd_val = cfg_q.low_cutoff_coeff;
			REG_HIGH_COEFF: rd_val = cfg_q.high_cutoff_coeff;
			REG_LOW_GAIN:   rd_val = cfg_q.low_band_gain;
			REG_MID_GAIN:   rd_val = cfg_q.mid_band_gain;
			REG_HIGH_GAIN:  rd_val = cfg_q.high_band_gain;
			default:        rd_val = '0;
		endcase
	end

	assign prdata = {{(PDATA_W-REG_W){1'b0}}, rd_val};
	assign cfg    = cfg_q;

endmodule
`default_nettype wire

FILE: design/tbeq_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbeq_mul: shared signed multiplier
// One 35 x 17 signed multiply per cycle with a registered product.
// ---------------------------------------------------------------------------
module tbeq_mul (
	input  wire logic                        clk,
	input  wire tbeq_pkg::mul_req_t          req,
	output logic signed [tbeq_pkg::PROD_W-1:0] product
);
	import tbeq_pkg::*;

	logic signed [PROD_W-1:0] product_q;
	logic signed [PROD_W-1:0] full;

	assign full = $signed(req.a) * $signed(req.b);

	// hold the product until the sequencer asks for the next one
	always_ff @(posedge clk) begin
		if (req.en) begin
			product_q <= full;
		end
	end

	assign product = product_q;

endmodule
`default_nettype wire

FILE: design/tbeq_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbeq_core: equalizer sequencer and datapath
// Steps the crossover poles and the band gains through the shared multiplier,
// accumulates the bands, rounds, saturates and presents the result.
// ---------------------------------------------------------------------------
module tbeq_core #(
	parameter int POLE_COUNT   = 4,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tbeq_pkg::cfg_t                 cfg,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output tbeq_pkg::mul_req_t                  mul_req,
	input  wire logic signed [tbeq_pkg::PROD_W-1:0] product
);
	import tbeq_pkg::*;

	localparam int POLE_FRAC = POLE_W - 1 - SAMPLE_WIDTH;
	localparam int OUT_SHIFT = GAIN_FRAC + POLE_FRAC;
	localparam int IDX_W     = (POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POLE_COUNT - 1);

	localparam logic signed [PROD_W:0] PMAX = (PROD_W+1)'((64'sd1 <<< (POLE_W-1)) - 1);
	localparam logic signed [PROD_W:0] PMIN = -PMAX - 1;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (OUT_SHIFT-1));
	localparam logic signed [ACC_W-1:0] SMAX =
		ACC_W'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
	localparam logic signed [ACC_W-1:0] SMIN = -SMAX - 1;

	localparam logic [1:0] BAND_LOW  = 2'd0;
	localparam logic [1:0] BAND_MID  = 2'd1;
	localparam logic [1:0] BAND_HIGH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POLE_MUL,
		ST_POLE_UPD,
		ST_BAND_MUL,
		ST_BAND_ACC,
		ST_ROUND
	} state_t;

	state_t                    state_q;
	logic                      high_sel_q;   // 0: low cascade, 1: high cascade
	logic [IDX_W-1:0]          idx_q;
	logic [1:0]                band_q;
	logic signed [POLE_W-1:0]  x_q;
	logic signed [POLE_W-1:0]  prev_q;
	logic signed [SAMPLE_WIDTH-1:0] s_q;
	logic signed [POLE_W-1:0]  low_poles_q  [POLE_COUNT];
	logic signed [POLE_W-1:0]  high_poles_q [POLE_COUNT];
	logic signed [SAMPLE_WIDTH-1:0] delay_q [DELAY_DEPTH];
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	logic                      out_valid_q;

	logic signed [POLE_W-1:0]  x_new;
	logic signed [POLE_W-1:0]  pole_cur;
	logic signed [OPA_W-1:0]   diff;
	logic signed [PROD_W-1:0]  upd;
	logic signed [PROD_W:0]    psum;
	logic signed [POLE_W-1:0]  pole_new;
	logic signed [OPA_W-1:0]   delayed;
	logic signed [OPA_W-1:0]   lows;
	logic signed [OPA_W-1:0]   highs;
	logic signed [OPA_W-1:0]   mids;
	logic signed [OPA_W-1:0]   band_val;
	logic [REG_W-1:0]          band_gain;
	logic signed [ACC_W-1:0]   rnd;
	logic signed [ACC_W-1:0]   shifted;
	logic signed [SAMPLE_WIDTH-1:0] res;
	logic                      out_free;

	// input sample in pole format
	assign x_new = {{(POLE_W-SAMPLE_WIDTH){sample_in[SAMPLE_WIDTH-1]}}, sample_in} <<< POLE_FRAC;

	// pole step
	assign pole_cur = high_sel_q ? high_poles_q[idx_q] : low_poles_q[idx_q];
	assign diff = {{(OPA_W-POLE_W){prev_q[POLE_W-1]}}, prev_q}
	            - {{(OPA_W-POLE_W){pole_cur[POLE_W-1]}}, pole_cur};
	assign upd  = product >>> COEFF_FRAC;
	assign psum = {{(PROD_W+1-POLE_W){pole_cur[POLE_W-1]}}, pole_cur}
	            + {upd[PROD_W-1], upd};

	always_comb begin
		if (psum > PMAX) begin
			pole_new = PMAX[POLE_W-1:0];
		end else if (psum < PMIN) begin
			pole_new = PMIN[POLE_W-1:0];
		end else begin
			pole_new = psum[POLE_W-1:0];
		end
	end

	// band split from the last poles and the oldest delayed sample
	assign delayed = {{(OPA_W-SAMPLE_WIDTH){delay_q[DELAY_DEPTH-1][SAMPLE_WIDTH-1]}},
	                  delay_q[DELAY_DEPTH-1]} <<< POLE_FRAC;
	assign lows  = {{(OPA_W-POLE_W){low_poles_q[POLE_COUNT-1][POLE_W-1]}},
	                low_poles_q[POLE_COUNT-1]};
	assign highs = delayed - {{(OPA_W-POLE_W){high_poles_q[POLE_COUNT-1][POLE_W-1]}},
	                          high_poles_q[POLE_COUNT-1]};
	assign mids  = delayed - (lows + highs);

	always_comb begin
		case (band_q)
			BAND_LOW: begin
				band_val  = lows;
				band_gain = cfg.low_band_gain;
			end
			BAND_MID: begin
				band_val  = mids;
				band_gain = cfg.mid_band_gain;
			end
			default: begin
				band_val  = highs;
				band_gain = cfg.high_band_gain;
			end
		endcase
	end

	// multiplier requests
	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = diff;
		mul_req.b  = {1'b0, high_sel_q ? cfg.high_cutoff_coeff : cfg.low_cutoff_coeff};
		if (state_q == ST_POLE_MUL) begin
			mul_req.en = 1'b1;
		end else if (state_q == ST_BAND_MUL) begin
			mul_req.en = 1'b1;
			mul_req.a  = band_val;
			mul_req.b  = {1'b0, band_gain};
		end
	end

	// round half up, then saturate
	assign rnd     = acc_q + HALF;
	assign shifted = rnd >>> OUT_SHIFT;

	always_comb begin
		if (shifted > SMAX) begin
			res = SMAX[SAMPLE_WIDTH-1:0];
		end else if (shifted < SMIN) begin
			res = SMIN[SAMPLE_WIDTH-1:0];
		end else begin
			res = shifted[SAMPLE_WIDTH-1:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			high_sel_q  <= 1'b0;
			idx_q       <= '0;
			band_q      <= BAND_LOW;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			for (int i = 0; i < POLE_COUNT; i++) begin
				low_poles_q[i]  <= '0;
				high_poles_q[i] <= '0;
			end
			for (int i = 0; i < DELAY_DEPTH; i++) begin
				delay_q[i] <= '0;
			end
		end else begin
			// drop the result once taken, unless a new one replaces it below
			if (out_valid_q && !out_stall && state_q != ST_ROUND) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q        <= x_new;
						prev_q     <= x_new;
						s_q        <= sample_in;
						high_sel_q <= 1'b0;
						idx_q      <= '0;
						acc_q      <= '0;
						state_q    <= ST_POLE_MUL;
					end
				end
				ST_POLE_MUL: begin
					state_q <= ST_POLE_UPD;
				end
				ST_POLE_UPD: begin
					if (high_sel_q) begin
						high_poles_q[idx_q] <= pole_new;
					end else begin
						low_poles_q[idx_q] <= pole_new;
					end
					if (idx_q != IDX_LAST) begin
						prev_q  <= pole_new;
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_POLE_MUL;
					end else if (!high_sel_q) begin
						// restart from the input sample on the high cascade
						high_sel_q <= 1'b1;
						idx_q      <= '0;
						prev_q     <= x_q;
						state_q    <= ST_POLE_MUL;
					end else begin
						band_q  <= BAND_LOW;
						state_q <= ST_BAND_MUL;
					end
				end
				ST_BAND_MUL: begin
					state_q <= ST_BAND_ACC;
				end
				ST_BAND_ACC: begin
					acc_q <= acc_q + {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};
					if (band_q == BAND_HIGH) begin
						state_q <= ST_ROUND;
					end else begin
						band_q  <= band_q + 1'b1;
						state_q <= ST_BAND_MUL;
					end
				end
				ST_ROUND: begin
					// hold until the previous result has been taken
					if (out_free) begin
						out_q       <= res;
						out_valid_q <= 1'b1;
						for (int i = DELAY_DEPTH - 1; i > 0; i--) begin
							delay_q[i] <= delay_q[i-1];
						end
						delay_q[0] <= s_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule
`default_nettype wire

FILE: design/three_band_equalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// three_band_equalizer: three-band audio equalizer, top level
// Two POLE_COUNT-pole low-pass crossover cascades split each sample into low,
// mid and high bands; each band is scaled by its gain and the sum saturated.
// ---------------------------------------------------------------------------
// Each sample request steps through the single shared 35x17 multiplier
// between acceptances: every pole of both cascades takes a multiply and an
// update step, every band a multiply and an accumulate step, then one round
// step, which waits while the previous result is still held, and one accept
// step. in_stall is high while a sample is being processed; the result sits
// in an output register, so a new sample is taken while it waits.
// Registers (16 bits at byte addresses 0x00..0x10): low cutoff coefficient,
// high cutoff coefficient (Q1.15), then low, mid and high gains (Q4.12,
// reset to unity). Write them only while the block is idle.
module three_band_equalizer #(
	parameter int POLE_COUNT   = 4,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tbeq_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [tbeq_pkg::PDATA_W-1:0]   pwdata,
	output logic      [tbeq_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
	import tbeq_pkg::*;

	cfg_t                     cfg;
	mul_req_t                 mul_req;
	logic signed [PROD_W-1:0] product;

	tbeq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tbeq_mul u_mul (
		.clk     (clk),
		.req     (mul_req),
		.product (product)
	);

	tbeq_core #(
		.POLE_COUNT   (POLE_COUNT),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.mul_req    (mul_req),
		.product    (product)
	);

endmodule
`default_nettype wire
